### src/evt2hid_pkg.sv
// Shared types, constants and the key code to HID usage table for the event translator.
package evt2hid_pkg;

   localparam logic [15:0] TYPE_SYNC = 16'd0;
   localparam logic [15:0] TYPE_KEY  = 16'd1;
   localparam logic [15:0] TYPE_REL  = 16'd2;

   localparam logic [15:0] BUTTON_FIRST = 16'h0110;
   localparam logic [15:0] BUTTON_LAST  = 16'h0112;
   localparam logic [15:0] AXIS_X       = 16'd0;
   localparam logic [15:0] AXIS_Y       = 16'd1;

   localparam logic [7:0] MOD_FIRST = 8'hE0;
   localparam logic [7:0] MOD_LAST  = 8'hE7;

   localparam logic [15:0] KEY_TABLE_SIZE = 16'd128;

   localparam logic KIND_KEY   = 1'b0;
   localparam logic KIND_MOUSE = 1'b1;

   localparam int  CSR_ADDR_W       = 3;
   localparam logic CSR_ENABLE_INDEX = 1'b0;

   localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_BUTTON,
      OP_MODIFIER,
      OP_KEY,
      OP_REL_X,
      OP_REL_Y,
      OP_SYNC
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [2:0]         sel;
      logic [7:0]         usage;
      logic               pressed;
      logic signed [31:0] value;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

   function automatic logic [7:0] key_usage_lookup(input logic [7:0] code);
      logic [7:0] u;
      unique case (code)
         8'd1:   u = 8'h29;
         8'd2:   u = 8'h1e;
         8'd3:   u = 8'h1f;
         8'd4:   u = 8'h20;
         8'd5:   u = 8'h21;
         8'd6:   u = 8'h22;
         8'd7:   u = 8'h23;
         8'd8:   u = 8'h24;
         8'd9:   u = 8'h25;
         8'd10:  u = 8'h26;
         8'd11:  u = 8'h27;
         8'd12:  u = 8'h2d;
         8'd13:  u = 8'h2e;
         8'd14:  u = 8'h2a;
         8'd15:  u = 8'h2b;
         8'd16:  u = 8'h14;
         8'd17:  u = 8'h1a;
         8'd18:  u = 8'h08;
         8'd19:  u = 8'h15;
         8'd20:  u = 8'h17;
         8'd21:  u = 8'h1c;
         8'd22:  u = 8'h18;
         8'd23:  u = 8'h0c;
         8'd24:  u = 8'h12;
         8'd25:  u = 8'h13;
         8'd26:  u = 8'h2f;
         8'd27:  u = 8'h30;
         8'd28:  u = 8'h28;
         8'd29:  u = 8'he0;
         8'd30:  u = 8'h04;
         8'd31:  u = 8'h16;
         8'd32:  u = 8'h07;
         8'd33:  u = 8'h09;
         8'd34:  u = 8'h0a;
         8'd35:  u = 8'h0b;
         8'd36:  u = 8'h0d;
         8'd37:  u = 8'h0e;
         8'd38:  u = 8'h0f;
         8'd39:  u = 8'h33;
         8'd40:  u = 8'h34;
         8'd41:  u = 8'h35;
         8'd42:  u = 8'he1;
         8'd43:  u = 8'h31;
         8'd44:  u = 8'h1d;
         8'd45:  u = 8'h1b;
         8'd46:  u = 8'h06;
         8'd47:  u = 8'h19;
         8'd48:  u = 8'h05;
         8'd49:  u = 8'h11;
         8'd50:  u = 8'h10;
         8'd51:  u = 8'h36;
         8'd52:  u = 8'h37;
         8'd53:  u = 8'h38;
         8'd54:  u = 8'he5;
         8'd55:  u = 8'h55;
         8'd56:  u = 8'he2;
         8'd57:  u = 8'h2c;
         8'd58:  u = 8'h39;
         8'd59:  u = 8'h3a;
         8'd60:  u = 8'h3b;
         8'd61:  u = 8'h3c;
         8'd62:  u = 8'h3d;
         8'd63:  u = 8'h3e;
         8'd64:  u = 8'h3f;
         8'd65:  u = 8'h40;
         8'd66:  u = 8'h41;
         8'd67:  u = 8'h42;
         8'd68:  u = 8'h43;
         8'd97:  u = 8'he4;
         8'd100: u = 8'he6;
         8'd102: u = 8'h4a;
         8'd103: u = 8'h52;
         8'd104: u = 8'h4b;
         8'd105: u = 8'h50;
         8'd106: u = 8'h4f;
         8'd107: u = 8'h4d;
         8'd108: u = 8'h51;
         8'd109: u = 8'h4e;
         8'd110: u = 8'h49;
         8'd111: u = 8'h4c;
         default: u = 8'h00;
      endcase
      return u;
   endfunction

endpackage

### src/evdev_event_to_hid_reports.sv
// Top level: input event words in, HID key and mouse report words out.
//
// req channel: one event word per handshake; tdata = event_type[15:0],
// event_code[31:16], event_value[63:32]. rsp channel: one report word;
// tuser = report_kind (0 key, 1 mouse); tdata = key_usage, modifier_mask,
// motion_x, motion_y, button_mask from bit 0 up. Mapped non-modifier key presses
// give key reports, sync events give mouse reports when enabled through the csr
// port (register 0 bit 0 at address 0). Other events at most update state.
// A word is classified on the cycle it is accepted and lands in a queue of
// QUEUE_DEPTH entries; the back end executes one entry per cycle unless a report
// is blocked behind a stalled rsp. A report passes through the queue and then
// the output register, and one event per cycle is sustained while rsp keeps up.
// The queue and the back end's output register decouple the sides: while rsp is
// stalled, state-only events keep draining and req stays ready until the
// queue fills behind a pending report. Reset clears the queue, output valid bit,
// modifier, button and motion state and enable bit; nothing needs to be swept.
module evdev_event_to_hid_reports #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [63:0]                        req_tdata,  // event_type, event_code, event_value
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [87:0]                        rsp_tdata,  // key_usage, modifier_mask, motion_x,
                                                          // motion_y, button_mask, pad
   output logic [0:0]                         rsp_tuser,  // report_kind
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [evt2hid_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);

   evt2hid_pkg::entry_type entry;
   evt2hid_pkg::head_type  head;
   logic                   full;
   logic                   push;
   logic                   pop;
   logic                   mouse_enable;

   logic               r_kind;
   logic [7:0]         r_usage;
   logic [7:0]         r_modifier;
   logic signed [31:0] r_x;
   logic signed [31:0] r_y;
   logic [2:0]         r_buttons;

   assign req_tready = !full;
   assign push       = req_tvalid && req_tready && (entry.op != evt2hid_pkg::OP_NONE);

   evt2hid_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .mouse_enable (mouse_enable)
   );

   evt2hid_front u_front (
      .event_type  (req_tdata[15:0]),
      .event_code  (req_tdata[31:16]),
      .event_value (req_tdata[63:32]),
      .entry       (entry)
   );

   evt2hid_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (entry),
      .pop        (pop),
      .full       (full),
      .head       (head)
   );

   evt2hid_back u_back (
      .clock        (clock),
      .reset        (reset),
      .mouse_enable (mouse_enable),
      .head         (head),
      .pop          (pop),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_kind     (r_kind),
      .out_usage    (r_usage),
      .out_modifier (r_modifier),
      .out_x        (r_x),
      .out_y        (r_y),
      .out_buttons  (r_buttons)
   );

   evt2hid_rsp_fmt u_fmt (
      .kind     (r_kind),
      .usage    (r_usage),
      .modifier (r_modifier),
      .x        (r_x),
      .y        (r_y),
      .buttons  (r_buttons),
      .tdata    (rsp_tdata),
      .tuser    (rsp_tuser)
   );

endmodule

### src/evt2hid_front.sv
// Front end: classifies an incoming event word into a queue entry or drops it.
module evt2hid_front (
   input  logic [15:0]           event_type,
   input  logic [15:0]           event_code,
   input  logic signed [31:0]    event_value,
   output evt2hid_pkg::entry_type entry
);

   logic [7:0]  usage;
   logic [15:0] btn_offset;
   logic        pressed;

   assign usage      = evt2hid_pkg::key_usage_lookup(event_code[7:0]);
   assign btn_offset = event_code - evt2hid_pkg::BUTTON_FIRST;
   assign pressed    = (event_value != 32'sd0);

   always_comb begin
      entry         = '0;
      entry.op      = evt2hid_pkg::OP_NONE;
      entry.usage   = usage;
      entry.pressed = pressed;
      entry.value   = event_value;
      if (event_type == evt2hid_pkg::TYPE_KEY) begin
         if (event_code >= evt2hid_pkg::BUTTON_FIRST &&
             event_code <= evt2hid_pkg::BUTTON_LAST) begin
            entry.op  = evt2hid_pkg::OP_BUTTON;
            entry.sel = {1'b0, btn_offset[1:0]};
         end else if (event_code < evt2hid_pkg::KEY_TABLE_SIZE && usage != 8'h00) begin
            if (usage >= evt2hid_pkg::MOD_FIRST && usage <= evt2hid_pkg::MOD_LAST) begin
               entry.op  = evt2hid_pkg::OP_MODIFIER;
               entry.sel = usage[2:0];
            end else if (pressed) begin
               entry.op = evt2hid_pkg::OP_KEY;
            end
         end
      end else if (event_type == evt2hid_pkg::TYPE_REL) begin
         if (event_code == evt2hid_pkg::AXIS_X) begin
            entry.op = evt2hid_pkg::OP_REL_X;
         end else if (event_code == evt2hid_pkg::AXIS_Y) begin
            entry.op = evt2hid_pkg::OP_REL_Y;
         end
      end else if (event_type == evt2hid_pkg::TYPE_SYNC) begin
         entry.op = evt2hid_pkg::OP_SYNC;
      end
   end

endmodule

### src/evt2hid_queue.sv
// Small FIFO of classified entries between the front and back ends.
module evt2hid_queue #(
   parameter int DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  evt2hid_pkg::entry_type push_entry,
   input  logic                   pop,
   output logic                   full,
   output evt2hid_pkg::head_type  head
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   evt2hid_pkg::entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign full       = (count_ff == FULL_CNT);
   assign head.valid = (count_ff != '0);
   assign head.entry = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### src/evt2hid_back.sv
// Back end: keeps modifier, button and motion state and drives the report output register.
module evt2hid_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  mouse_enable,
   input  evt2hid_pkg::head_type head,
   output logic                  pop,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic                  out_kind,
   output logic [7:0]            out_usage,
   output logic [7:0]            out_modifier,
   output logic signed [31:0]    out_x,
   output logic signed [31:0]    out_y,
   output logic [2:0]            out_buttons
);

   logic [7:0]         modifier_ff, modifier_in;
   logic [2:0]         buttons_ff, buttons_in;
   logic signed [31:0] x_ff, x_in;
   logic signed [31:0] y_ff, y_in;

   logic               valid_ff, valid_in;
   logic               kind_ff, kind_in;
   logic [7:0]         usage_ff, usage_in;
   logic [7:0]         rmod_ff, rmod_in;
   logic signed [31:0] rx_ff, rx_in;
   logic signed [31:0] ry_ff, ry_in;
   logic [2:0]         rbtn_ff, rbtn_in;

   evt2hid_pkg::entry_type e;
   logic               emits;
   logic signed [31:0] acc;
   logic [32:0]        sum;
   logic signed [31:0] sat;
   logic [7:0]         mod_bit;
   logic [2:0]         btn_bit;

   assign e     = head.entry;
   assign emits = (e.op == evt2hid_pkg::OP_KEY) ||
                  (e.op == evt2hid_pkg::OP_SYNC && mouse_enable);
   assign pop   = head.valid && (!emits || !valid_ff || out_ready);

   assign acc = (e.op == evt2hid_pkg::OP_REL_Y) ? y_ff : x_ff;
   assign sum = {acc[31], acc} + {e.value[31], e.value};
   always_comb begin
      if (sum[32] != sum[31]) begin
         sat = sum[32] ? evt2hid_pkg::SAT_MIN : evt2hid_pkg::SAT_MAX;
      end else begin
         sat = sum[31:0];
      end
   end

   assign mod_bit = 8'(1) << e.sel;
   assign btn_bit = 3'(1) << e.sel[1:0];

   always_comb begin
      modifier_in = modifier_ff;
      buttons_in  = buttons_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      valid_in    = valid_ff && !out_ready;
      kind_in     = kind_ff;
      usage_in    = usage_ff;
      rmod_in     = rmod_ff;
      rx_in       = rx_ff;
      ry_in       = ry_ff;
      rbtn_in     = rbtn_ff;
      if (pop) begin
         unique case (e.op)
            evt2hid_pkg::OP_BUTTON: begin
               buttons_in = e.pressed ? (buttons_ff | btn_bit) : (buttons_ff & ~btn_bit);
            end
            evt2hid_pkg::OP_MODIFIER: begin
               modifier_in = e.pressed ? (modifier_ff | mod_bit) : (modifier_ff & ~mod_bit);
            end
            evt2hid_pkg::OP_KEY: begin
               valid_in = 1'b1;
               kind_in  = evt2hid_pkg::KIND_KEY;
               usage_in = e.usage;
               rmod_in  = modifier_ff;
               rx_in    = '0;
               ry_in    = '0;
               rbtn_in  = '0;
            end
            evt2hid_pkg::OP_REL_X: begin
               x_in = sat;
            end
            evt2hid_pkg::OP_REL_Y: begin
               y_in = sat;
            end
            evt2hid_pkg::OP_SYNC: begin
               if (mouse_enable) begin
                  valid_in = 1'b1;
                  kind_in  = evt2hid_pkg::KIND_MOUSE;
                  usage_in = '0;
                  rmod_in  = modifier_ff;
                  rx_in    = x_ff;
                  ry_in    = y_ff;
                  rbtn_in  = buttons_ff;
               end
               x_in = '0;
               y_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modifier_ff <= '0;
         buttons_ff  <= '0;
         x_ff        <= '0;
         y_ff        <= '0;
         valid_ff    <= 1'b0;
      end else begin
         modifier_ff <= modifier_in;
         buttons_ff  <= buttons_in;
         x_ff        <= x_in;
         y_ff        <= y_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      usage_ff <= usage_in;
      rmod_ff  <= rmod_in;
      rx_ff    <= rx_in;
      ry_ff    <= ry_in;
      rbtn_ff  <= rbtn_in;
   end

   assign out_valid    = valid_ff;
   assign out_kind     = kind_ff;
   assign out_usage    = usage_ff;
   assign out_modifier = rmod_ff;
   assign out_x        = rx_ff;
   assign out_y        = ry_ff;
   assign out_buttons  = rbtn_ff;

endmodule

### src/evt2hid_csr.sv
// Configuration register block: the mouse report enable bit behind an APB-style port.
module evt2hid_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [evt2hid_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready,
   output logic                               mouse_enable
);

   logic enable_ff, enable_in;
   logic hit;

   assign hit        = (csr_paddr[2] == evt2hid_pkg::CSR_ENABLE_INDEX);
   assign csr_pready = 1'b1;
   assign csr_prdata = hit ? {31'b0, enable_ff} : 32'b0;

   always_comb begin
      enable_in = enable_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         enable_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
      end else begin
         enable_ff <= enable_in;
      end
   end

   assign mouse_enable = enable_ff;

endmodule

### src/evt2hid_queue_top_note.sv
// Queue entry layout note: op, sel, usage, pressed and value, as in evt2hid_pkg::entry_type.

### src/evt2hid_rsp_pack.sv
// Response word packing helper kept beside the back end.
module evt2hid_rsp_fmt (
   input  logic               kind,
   input  logic [7:0]         usage,
   input  logic [7:0]         modifier,
   input  logic signed [31:0] x,
   input  logic signed [31:0] y,
   input  logic [2:0]         buttons,
   output logic [87:0]        tdata,
   output logic [0:0]         tuser
);

   assign tdata = {5'b0, buttons, y, x, modifier, usage};
   assign tuser = kind;

endmodule

### tb/tb_evdev_event_to_hid_reports.sv
// Self-checking testbench for the input event to HID report translator.
module tb_evdev_event_to_hid_reports;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 12;
   localparam int HOLD_CYCLES  = 300;
   localparam int HOLD_WORDS   = 48;
   localparam int ADDR_W       = evt2hid_pkg::CSR_ADDR_W;

   localparam bit [ADDR_W-1:0] ENABLE_ADDR = ADDR_W'(evt2hid_pkg::CSR_ENABLE_INDEX) << 2;
   localparam bit [ADDR_W-1:0] UNUSED_ADDR = ADDR_W'(4);  // register 1, not implemented

   localparam bit [15:0] KEY_NONE        = 16'd0;
   localparam bit [15:0] KEY_LCTRL       = 16'd29;
   localparam bit [15:0] KEY_A           = 16'd30;
   localparam bit [15:0] KEY_RCTRL       = 16'd97;
   localparam bit [15:0] KEY_LAST_MAPPED = 16'd111;
   localparam bit [15:0] MOD_CODES [6]   = '{16'd29, 16'd42, 16'd54, 16'd56, 16'd97, 16'd100};

   // key code to usage, codes 0..68 and 96..111; everything else maps to nothing
   localparam bit [7:0] KEYMAP_LO [69] = '{
      8'h00, 8'h29, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23,
      8'h24, 8'h25, 8'h26, 8'h27, 8'h2d, 8'h2e, 8'h2a, 8'h2b,
      8'h14, 8'h1a, 8'h08, 8'h15, 8'h17, 8'h1c, 8'h18, 8'h0c,
      8'h12, 8'h13, 8'h2f, 8'h30, 8'h28, 8'he0, 8'h04, 8'h16,
      8'h07, 8'h09, 8'h0a, 8'h0b, 8'h0d, 8'h0e, 8'h0f, 8'h33,
      8'h34, 8'h35, 8'he1, 8'h31, 8'h1d, 8'h1b, 8'h06, 8'h19,
      8'h05, 8'h11, 8'h10, 8'h36, 8'h37, 8'h38, 8'he5, 8'h55,
      8'he2, 8'h2c, 8'h39, 8'h3a, 8'h3b, 8'h3c, 8'h3d, 8'h3e,
      8'h3f, 8'h40, 8'h41, 8'h42, 8'h43};
   localparam bit [7:0] KEYMAP_HI [16] = '{
      8'h00, 8'he4, 8'h00, 8'h00, 8'he6, 8'h00, 8'h4a, 8'h52,
      8'h4b, 8'h50, 8'h4f, 8'h4d, 8'h51, 8'h4e, 8'h49, 8'h4c};

   typedef struct packed {
      bit               kind;
      bit [7:0]         usage;
      bit [7:0]         mods;
      bit signed [31:0] mx;
      bit signed [31:0] my;
      bit [2:0]         buttons;
   } hid_report_type;

   typedef enum bit [1:0] {ROW_PREDICT, ROW_NO_REPORT, ROW_PINNED} check_mode_type;

   typedef struct packed {
      bit [15:0]      etype;
      bit [15:0]      ecode;
      bit [31:0]      evalue;
      check_mode_type mode;
      hid_report_type pinned;
   } directed_row_type;

   localparam hid_report_type NO_REPORT = '0;

   localparam directed_row_type DIRECTED [25] = '{
      '{evt2hid_pkg::TYPE_REL,  evt2hid_pkg::AXIS_X, 32'd100, ROW_NO_REPORT, NO_REPORT},
      '{evt2hid_pkg::TYPE_SYNC, 16'h0,               32'h0,   ROW_NO_REPORT, NO_REPORT},
      '{evt2hid_pkg::TYPE_SYNC, 16'h0,               32'h0,   ROW_PINNED,
        '{evt2hid_pkg::KIND_MOUSE, 8'h00, 8'h00, 32'sd0, 32'sd0, 3'd0}},
      '{evt2hid_pkg::TYPE_KEY,  KEY_A,               32'd1,   ROW_PINNED,
        '{evt2hid_pkg::KIND_KEY, 8'h04, 8'h00, 32'sd0, 32'sd0, 3'd0}},
      '{evt2hid_pkg::TYPE_KEY,  KEY_LCTRL,       32'd1,         ROW_NO_REPORT, NO_REPORT},
      '{evt2hid_pkg::TYPE_KEY,  KEY_A,           32'd2,         ROW_PREDICT,   NO_REPORT},
      '{evt2hid_pkg::TYPE_KEY,  KEY_A,           32'd0,         ROW_NO_REPORT, NO_REPORT},
      '{evt2hid_pkg::TYPE_KEY,  KEY_RCTRL,       32'hFFFF_FFFF, ROW_NO_REPORT, NO_REPORT},
      '{evt2hid_pkg::TYPE_KEY,  evt2hid_pkg::BUTTON_FIRST, 32'd1, ROW_NO_REPORT, NO_REPORT},
      '{evt2hid_pkg::TYPE_KEY,  evt2hid_pkg::BUTTON_LAST, 32'h8000_0000, ROW_NO_REPORT,
        NO_REPORT},
      '{evt2hid_pkg::TYPE_KEY,  KEY_NONE,        32'd1,         ROW_NO_REPORT, NO_REPORT},
      '{evt2hid_pkg::TYPE_KEY,  evt2hid_pkg::KEY_TABLE_SIZE, 32'd1, ROW_NO_REPORT, NO_REPORT},
      '{evt2hid_pkg::TYPE_KEY,  16'hFFFF,        32'd1,         ROW_NO_REPORT, NO_REPORT},
      '{evt2hid_pkg::TYPE_REL,  evt2hid_pkg::AXIS_X, evt2hid_pkg::SAT_MAX, ROW_PREDICT,
        NO_REPORT},
      '{evt2hid_pkg::TYPE_REL,  evt2hid_pkg::AXIS_X, 32'd1,     ROW_PREDICT,   NO_REPORT},
      '{evt2hid_pkg::TYPE_REL,  evt2hid_pkg::AXIS_Y, evt2hid_pkg::SAT_MIN, ROW_PREDICT,
        NO_REPORT},
      '{evt2hid_pkg::TYPE_REL,  evt2hid_pkg::AXIS_Y, 32'hFFFF_FFFF, ROW_PREDICT, NO_REPORT},
      '{evt2hid_pkg::TYPE_REL,  evt2hid_pkg::AXIS_Y + 16'd1, 32'd5, ROW_NO_REPORT, NO_REPORT},
      '{evt2hid_pkg::TYPE_SYNC, 16'h0,           32'h0,         ROW_PINNED,
        '{evt2hid_pkg::KIND_MOUSE, 8'h00, 8'h11, evt2hid_pkg::SAT_MAX, evt2hid_pkg::SAT_MIN,
          3'b101}},
      '{16'hFFFF,               KEY_A,           32'd1,         ROW_NO_REPORT, NO_REPORT},
      '{evt2hid_pkg::TYPE_KEY,  KEY_LAST_MAPPED, 32'd1,         ROW_PREDICT,   NO_REPORT},
      '{evt2hid_pkg::TYPE_KEY,  evt2hid_pkg::BUTTON_FIRST + 16'd1, 32'd0, ROW_NO_REPORT,
        NO_REPORT},
      '{evt2hid_pkg::TYPE_KEY,  evt2hid_pkg::BUTTON_FIRST, 32'd0, ROW_NO_REPORT, NO_REPORT},
      '{evt2hid_pkg::TYPE_KEY,  KEY_LCTRL,       32'd0,         ROW_NO_REPORT, NO_REPORT},
      '{evt2hid_pkg::TYPE_SYNC, 16'hFFFF,        32'hFFFF_FFFF, ROW_PREDICT,   NO_REPORT}};

   localparam bit PHASE_ENABLE [3] = '{1'b1, 1'b0, 1'b1};
   localparam int PHASE_WORDS  [3] = '{550, 350, 750};

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [63:0]       req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [87:0]       rsp_tdata;
   logic [0:0]        rsp_tuser;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [31:0]       csr_pwdata;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   // predicted block state
   bit               mouse_enable;
   bit [7:0]         mods_held;
   bit signed [31:0] x_motion;
   bit signed [31:0] y_motion;
   bit [2:0]         buttons_held;

   hid_report_type pending_reports[$];
   check_mode_type check_mode;
   hid_report_type pinned_report;
   int             mismatches;
   int             cycle_count;
   int             rx_hold;
   bit             rx_quiet;
   bit             tx_quiet;

   evdev_event_to_hid_reports uut (.*);

   always #5 clock = ~clock;

   function automatic bit [7:0] usage_of(input bit [15:0] code);
      if (code < 16'd69)
         return KEYMAP_LO[code];
      if (code >= 16'd96 && code < 16'd112)
         return KEYMAP_HI[code - 16'd96];
      return 8'h00;
   endfunction

   function automatic bit signed [31:0] sat_add(input bit signed [31:0] a,
                                                input bit signed [31:0] b);
      longint s;
      s = longint'(a) + longint'(b);
      if (s > longint'(evt2hid_pkg::SAT_MAX))
         return evt2hid_pkg::SAT_MAX;
      if (s < longint'(evt2hid_pkg::SAT_MIN))
         return evt2hid_pkg::SAT_MIN;
      return s[31:0];
   endfunction

   function automatic void translate_event(input bit [15:0] etype, input bit [15:0] ecode,
                                           input bit [31:0] evalue, output bit produced,
                                           output hid_report_type rep);
      bit       pressed;
      bit [7:0] usage;
      bit [2:0] bbit;
      bit [7:0] mbit;
      produced = 1'b0;
      rep = '0;
      pressed = (evalue != 32'd0);
      case (etype)
         evt2hid_pkg::TYPE_KEY: begin
            if (ecode >= evt2hid_pkg::BUTTON_FIRST && ecode <= evt2hid_pkg::BUTTON_LAST) begin
               bbit = 3'b001 << (ecode - evt2hid_pkg::BUTTON_FIRST);
               buttons_held = pressed ? (buttons_held | bbit) : (buttons_held & ~bbit);
            end else begin
               usage = usage_of(ecode);
               if (usage >= evt2hid_pkg::MOD_FIRST && usage <= evt2hid_pkg::MOD_LAST) begin
                  mbit = 8'b1 << (usage - evt2hid_pkg::MOD_FIRST);
                  mods_held = pressed ? (mods_held | mbit) : (mods_held & ~mbit);
               end else if (usage != 8'h00 && pressed) begin
                  produced = 1'b1;
                  rep.kind = evt2hid_pkg::KIND_KEY;
                  rep.usage = usage;
                  rep.mods = mods_held;
               end
            end
         end
         evt2hid_pkg::TYPE_REL: begin
            if (ecode == evt2hid_pkg::AXIS_X)
               x_motion = sat_add(x_motion, evalue);
            else if (ecode == evt2hid_pkg::AXIS_Y)
               y_motion = sat_add(y_motion, evalue);
         end
         evt2hid_pkg::TYPE_SYNC: begin
            if (mouse_enable) begin
               produced = 1'b1;
               rep.kind = evt2hid_pkg::KIND_MOUSE;
               rep.mods = mods_held;
               rep.mx = x_motion;
               rep.my = y_motion;
               rep.buttons = buttons_held;
            end
            x_motion = '0;
            y_motion = '0;
         end
         default: ;
      endcase
   endfunction

   task automatic check_field(input string name, input bit [63:0] want, input bit [63:0] got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   // monitor: results, accepted words and csr accesses, all sampled at the edge
   always @(posedge clock) begin
      hid_report_type got;
      hid_report_type want;
      hid_report_type predicted;
      bit             produced;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.kind = rsp_tuser[0];
            got.usage = rsp_tdata[7:0];
            got.mods = rsp_tdata[15:8];
            got.mx = rsp_tdata[47:16];
            got.my = rsp_tdata[79:48];
            got.buttons = rsp_tdata[82:80];
            if (pending_reports.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected report: expected none, actual %h", $time, got);
            end else begin
               want = pending_reports.pop_front();
               check_field("report_kind", want.kind, got.kind);
               check_field("key_usage", want.usage, got.usage);
               check_field("modifier_mask", want.mods, got.mods);
               check_field("motion_x", want.mx, got.mx);
               check_field("motion_y", want.my, got.my);
               check_field("button_mask", want.buttons, got.buttons);
            end
         end
         if (req_tvalid && req_tready) begin
            translate_event(req_tdata[15:0], req_tdata[31:16], req_tdata[63:32], produced,
                            predicted);
            case (check_mode)
               ROW_PINNED:  pending_reports.push_back(pinned_report);
               ROW_PREDICT: if (produced) pending_reports.push_back(predicted);
               default: ;
            endcase
         end
         if (csr_psel && csr_penable && csr_pready &&
             csr_paddr[ADDR_W-1:2] == evt2hid_pkg::CSR_ENABLE_INDEX) begin
            if (csr_pwrite)
               mouse_enable = csr_pwdata[0];
            else if (csr_prdata !== {31'b0, mouse_enable}) begin
               mismatches++;
               $display("%0t: csr read mismatch: expected %0h, actual %0h", $time,
                        {31'b0, mouse_enable}, csr_prdata);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** evdev_event_to_hid_reports: FAILED **");
         $finish;
      end
   end

   // result side: random stalls, quiet stretches, and a long hold on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            if ($urandom_range(0, 63) == 0)
               rx_quiet = !rx_quiet;
            stall_left = rx_quiet ? 0 : $urandom_range(0, 15);
         end
         if (rx_hold > 0) begin
            rx_hold--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_event(input bit [15:0] etype, input bit [15:0] ecode,
                             input bit [31:0] evalue, input check_mode_type mode,
                             input hid_report_type pinned);
      int gap;
      gap = tx_quiet ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {evalue, ecode, etype};
      check_mode <= mode;
      pinned_report <= pinned;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input bit wr, input bit [ADDR_W-1:0] addr,
                             input bit [31:0] wdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= addr;
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_mouse_enable(input bit en);
      bit [31:0] word;
      word = $urandom;
      word[0] = en;
      wait_drained();
      csr_access(1'b1, ENABLE_ADDR, word);
      csr_access(1'b0, ENABLE_ADDR, '0);
   endtask

   task automatic random_event(output bit [15:0] etype, output bit [15:0] ecode,
                               output bit [31:0] evalue);
      int sel;
      int r;
      sel = $urandom_range(0, 99);
      r = $urandom_range(0, 9);
      etype = evt2hid_pkg::TYPE_KEY;
      ecode = 16'($urandom_range(0, 127));
      evalue = (r < 4) ? 32'd1 : (r < 7) ? 32'd0 : (r < 9) ? 32'd2 : $urandom;
      if (sel < 30) begin
      end else if (sel < 40) begin
         ecode = MOD_CODES[$urandom_range(0, 5)];
      end else if (sel < 48) begin
         ecode = evt2hid_pkg::BUTTON_FIRST + 16'($urandom_range(0, 2));
      end else if (sel < 68) begin
         etype = evt2hid_pkg::TYPE_REL;
         ecode = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1));
         r = $urandom_range(0, 9);
         if (r < 6)
            evalue = 32'($urandom_range(0, 200)) - 32'd100;
         else if (r < 8)
            evalue = $urandom_range(0, 1) ?
                     evt2hid_pkg::SAT_MAX - 32'($urandom_range(0, 3)) :
                     evt2hid_pkg::SAT_MIN + 32'($urandom_range(0, 3));
         else
            evalue = $urandom;
      end else if (sel < 82) begin
         etype = evt2hid_pkg::TYPE_SYNC;
         ecode = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0;
         evalue = ($urandom_range(0, 3) == 0) ? $urandom : 32'h0;
      end else if (sel < 90) begin
         ecode = 16'($urandom);
      end else begin
         etype = 16'($urandom);
         ecode = 16'($urandom);
         evalue = $urandom;
      end
   endtask

   initial begin
      bit [15:0] t;
      bit [15:0] c;
      bit [31:0] v;
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      check_mode = ROW_PREDICT;
      pinned_report = NO_REPORT;
      mouse_enable = 1'b0;
      mods_held = '0;
      x_motion = '0;
      y_motion = '0;
      buttons_held = '0;
      mismatches = 0;
      cycle_count = 0;
      rx_hold = 0;
      rx_quiet = 1'b0;
      tx_quiet = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // write to an unimplemented register must leave reports disabled
      csr_access(1'b1, UNUSED_ADDR, $urandom | 32'd1);
      csr_access(1'b0, ENABLE_ADDR, '0);
      foreach (DIRECTED[i]) begin
         if (i == 2)
            set_mouse_enable(1'b1);
         send_event(DIRECTED[i].etype, DIRECTED[i].ecode, DIRECTED[i].evalue,
                    DIRECTED[i].mode, DIRECTED[i].pinned);
      end

      for (int p = 0; p < 3; p++) begin
         set_mouse_enable(PHASE_ENABLE[p]);
         if (p == 2) begin
            // back up the result side while key presses keep coming
            rx_hold = HOLD_CYCLES;
            tx_quiet = 1'b1;
            repeat (HOLD_WORDS)
               send_event(evt2hid_pkg::TYPE_KEY, 16'($urandom_range(1, 68)), 32'd1,
                          ROW_PREDICT, NO_REPORT);
            tx_quiet = 1'b0;
         end
         repeat (PHASE_WORDS[p]) begin
            if ($urandom_range(0, 63) == 0)
               tx_quiet = !tx_quiet;
            random_event(t, c, v);
            send_event(t, c, v, ROW_PREDICT, NO_REPORT);
         end
      end
      wait_drained();

      if (mismatches == 0)
         $display("** evdev_event_to_hid_reports: PASSED **");
      else
         $display("** evdev_event_to_hid_reports: FAILED **");
      $finish;
   end

endmodule
